>>> hdl/frmq_pkg.sv
// Package for the flushing ring message queue.
// Shared field widths, operation and result codes, register map, state type.
// No dependencies.
package frmq_pkg;

  localparam int CAP_W = 7;   // capacity register and fill count width
  localparam int MSG_W = 32;  // message port width

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  // operation codes
  localparam logic OP_PUSH  = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  // result kinds
  localparam logic KIND_ACK = 1'b0;
  localparam logic KIND_MSG = 1'b1;

  // register index (paddr[2])
  localparam logic REG_CAPACITY = 1'b0;

  typedef enum logic {
    ST_IDLE,
    ST_DRAIN
  } state_t;

endpackage

>>> hdl/flushing_ring_message_queue.sv
// Flushing ring message queue: top level with pointers, control and APB register.
// Depends on frmq_pkg and frmq_ram.
//
// Usage
//   Input channel: an item (operation, msg_data) is taken on a clock edge with
//   start high and busy low. Results come out on result_valid for one cycle
//   each; the receiver has no way to stall them.
//   Push: stores msg_data at the tail. A push on a full queue first drops all
//   held entries (flushed = 1). One ack result follows in the cycle after the
//   push is taken; doorbell marks a fill count of one. A push does not raise
//   busy, so a push can be taken every cycle while no drain holds busy high.
//   Drain: busy rises after a drain of two or more entries is taken and stays
//   high until the final entry is read; one entry is read from the ring RAM
//   per cycle, each word coming out in the cycle after its read (registered
//   read data), the final one with last set. An empty drain gives no result
//   and does not raise busy. The single RAM read port sets the drain rate.
//   Config: APB register 0 (byte address 0) is capacity, 0 acting as 1 and
//   values above DEPTH acting as DEPTH. Writing it empties the queue.
//   Reset: synchronous rst empties the queue and sets capacity to 64; the RAM
//   contents are left as they are and are never read before being written.
module flushing_ring_message_queue
  import frmq_pkg::*;
#(
  parameter int DEPTH      = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst,
  // command channel
  input  logic             start,
  output logic             busy,
  input  logic             operation,
  input  logic [MSG_W-1:0] msg_data,
  // result channel
  output logic             result_valid,
  output logic             result_kind,
  output logic [MSG_W-1:0] msg_out,
  output logic             last,
  output logic             flushed,
  output logic             doorbell,
  output logic [CAP_W-1:0] fill_count,
  // APB register port
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // control state
  state_t           state, state_next;
  logic [CAP_W-1:0] capacity;
  logic [PTR_W-1:0] head, head_next;
  logic [PTR_W-1:0] tail, tail_next;
  logic [CAP_W-1:0] count, count_next;

  // result registers: push ack and drain read pipeline
  logic             ack_valid;
  logic             ack_flushed;
  logic             ack_bell;
  logic [CAP_W-1:0] ack_fill;
  logic             rd_valid;
  logic             rd_last;
  logic [CAP_W-1:0] rd_fill;

  logic                  push_acc, drain_acc, cfg_wr, issue, is_full;
  logic [CAP_W-1:0]      cap_raw, cap_act;
  logic [PTR_W-1:0]      tail_base, head_base, tail_adv, head_adv;
  logic [PTR_W:0]        tail_inc, head_inc;
  logic [CAP_W-1:0]      count_push, count_drain;
  logic [DATA_WIDTH-1:0] ram_wdata, ram_rdata;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_CAPACITY);
  assign prdata = (paddr[2] == REG_CAPACITY) ? 32'(capacity) : 32'd0;

  // effective ring size
  assign cap_raw = (capacity == '0) ? CAP_W'(1) : capacity;
  assign cap_act = (32'(cap_raw) > DEPTH) ? CAP_W'(DEPTH) : cap_raw;

  assign push_acc  = start && !busy && (operation == OP_PUSH);
  assign drain_acc = start && !busy && (operation == OP_DRAIN);

  // push path: flush when full, then write at tail
  assign is_full    = 32'(count) >= 32'(cap_act);
  assign tail_base  = (is_full || (32'(tail) >= 32'(cap_act))) ? '0 : tail;
  assign tail_inc   = {1'b0, tail_base} + 1'b1;
  assign tail_adv   = (32'(tail_inc) >= 32'(cap_act)) ? '0 : tail_inc[PTR_W-1:0];
  assign count_push = (is_full ? '0 : count) + 1'b1;
  assign ram_wdata  = DATA_WIDTH'(msg_data);

  // drain path: one read per cycle at head
  assign head_base   = (32'(head) >= 32'(cap_act)) ? '0 : head;
  assign head_inc    = {1'b0, head_base} + 1'b1;
  assign head_adv    = (32'(head_inc) >= 32'(cap_act)) ? '0 : head_inc[PTR_W-1:0];
  assign count_drain = count - 1'b1;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (drain_acc && (count != '0) && (count_drain != '0)) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (count_drain == '0) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    busy  = 1'b0;
    issue = 1'b0;
    unique case (state)
      ST_IDLE: begin
        issue = drain_acc && (count != '0);
      end
      ST_DRAIN: begin
        busy  = 1'b1;
        issue = 1'b1;
      end
      default: begin
        busy  = 1'b0;
        issue = 1'b0;
      end
    endcase
  end

  // pointer and count updates
  always_comb begin
    head_next  = head;
    tail_next  = tail;
    count_next = count;
    priority if (push_acc) begin
      if (is_full) begin
        head_next = '0;
      end
      tail_next  = tail_adv;
      count_next = count_push;
    end else if (issue) begin
      head_next  = head_adv;
      count_next = count_drain;
    end else begin
      count_next = count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      capacity  <= CAP_RESET;
      head      <= '0;
      tail      <= '0;
      count     <= '0;
      ack_valid <= 1'b0;
      rd_valid  <= 1'b0;
    end else begin
      state     <= state_next;
      ack_valid <= push_acc;
      rd_valid  <= issue;
      if (cfg_wr) begin
        // new size: start from an empty ring
        capacity <= pwdata[CAP_W-1:0];
        head     <= '0;
        tail     <= '0;
        count    <= '0;
      end else begin
        head  <= head_next;
        tail  <= tail_next;
        count <= count_next;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (push_acc) begin
      ack_flushed <= is_full;
      ack_bell    <= (count_push == CAP_W'(1));
      ack_fill    <= count_push;
    end
    if (issue) begin
      rd_last <= (count_drain == '0);
      rd_fill <= count_drain;
    end
  end

  frmq_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (push_acc),
    .waddr (tail_base),
    .wdata (ram_wdata),
    .re    (issue),
    .raddr (head_base),
    .rdata (ram_rdata)
  );

  // ack and drained words never share a cycle
  assign result_valid = ack_valid || rd_valid;
  assign result_kind  = rd_valid ? KIND_MSG : KIND_ACK;
  assign msg_out      = rd_valid ? MSG_W'(ram_rdata) : '0;
  assign last         = ack_valid || (rd_valid && rd_last);
  assign flushed      = ack_valid && ack_flushed;
  assign doorbell     = ack_valid && ack_bell;
  assign fill_count   = rd_valid ? rd_fill : ack_fill;

endmodule

>>> hdl/frmq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module frmq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hdl/frmq_chk.sv
// Port-level checker for the flushing ring message queue, bound to the top level.
// Depends on frmq_pkg.
module frmq_chk
  import frmq_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input logic             operation,
  input logic             result_valid,
  input logic             result_kind,
  input logic             last,
  input logic             flushed,
  input logic             doorbell,
  input logic [CAP_W-1:0] fill_count
);

  // a taken push is acknowledged in the next cycle
  a_push_ack: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (operation == OP_PUSH)) |=>
      (result_valid && (result_kind == KIND_ACK)))
    else $error("push not acknowledged");

  // an ack is always the final result of its item
  a_ack_last: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (result_kind == KIND_ACK)) |-> last)
    else $error("ack without last");

  // a drained word is last exactly when the queue is left empty
  a_drain_last: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (result_kind == KIND_MSG)) |-> (last == (fill_count == '0)))
    else $error("drain last mismatch");

  // doorbell means a fill count of one
  a_bell: assert property (@(posedge clk) disable iff (rst)
    (result_valid && doorbell) |-> (fill_count == CAP_W'(1)))
    else $error("doorbell with wrong fill");

  // a flush leaves only the new word, which rings the doorbell
  a_flush: assert property (@(posedge clk) disable iff (rst)
    (result_valid && flushed) |-> (doorbell && (fill_count == CAP_W'(1))))
    else $error("flush with wrong fill");

endmodule

bind flushing_ring_message_queue frmq_chk u_frmq_chk (.*);

>>> tb/sv/flushing_ring_message_queue_tb.sv
// Testbench for the flushing ring message queue: clocked driver and monitor,
// an in-bench ring predictor and APB capacity writes between phases.
// Depends on frmq_pkg and the flushing_ring_message_queue RTL.
`timescale 1ns / 100ps

module flushing_ring_message_queue_tb;
  import frmq_pkg::*;

  localparam int RING_DEPTH    = 64;
  localparam int QUIET_LIMIT   = 2000;  // cycles with no item or result taken
  localparam int SETTLE_CYCLES = 8;     // drain-of-empty may still be in flight
  localparam int MAX_REPORTS   = 10;
  localparam int GAP_PERCENT   = 28;
  localparam logic [2:0] CAPACITY_ADDR = {REG_CAPACITY, 2'b00};

  typedef struct {
    logic             op;
    logic [MSG_W-1:0] data;
  } queue_item_t;

  typedef struct packed {
    logic             kind;
    logic [MSG_W-1:0] msg;
    logic             last;
    logic             flushed;
    logic             doorbell;
    logic [CAP_W-1:0] fill;
  } queue_result_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic             busy;
  logic             operation = OP_PUSH;
  logic [MSG_W-1:0] msg_data = '0;
  logic             result_valid;
  logic             result_kind;
  logic [MSG_W-1:0] msg_out;
  logic             last;
  logic             flushed;
  logic             doorbell;
  logic [CAP_W-1:0] fill_count;
  logic             psel = 1'b0;
  logic             penable = 1'b0;
  logic             pwrite = 1'b0;
  logic [2:0]       paddr = '0;
  logic [31:0]      pwdata = '0;
  logic [31:0]      prdata;
  logic             pready;

  // Items waiting for the driver, and results the ring predictor expects.
  queue_item_t   pending_items[$];
  queue_result_t expected_results[$];

  // Predictor copy of the ring.
  logic [MSG_W-1:0] ring_words[RING_DEPTH];
  int               ring_head;
  int               ring_tail;
  int               ring_held;
  logic [CAP_W-1:0] ring_cap;

  int  mismatches = 0;
  int  quiet_cycles = 0;
  bit  steady_feed = 1'b0;  // when set the driver inserts no random idle gaps

  flushing_ring_message_queue #(
    .DEPTH(RING_DEPTH),
    .DATA_WIDTH(MSG_W)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .operation(operation),
    .msg_data(msg_data),
    .result_valid(result_valid),
    .result_kind(result_kind),
    .msg_out(msg_out),
    .last(last),
    .flushed(flushed),
    .doorbell(doorbell),
    .fill_count(fill_count),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Ring predictor
  // ---------------------------------------------------------------------
  function automatic int effective_capacity();
    if (ring_cap == 0) return 1;            // zero behaves as one entry
    if (ring_cap > RING_DEPTH) return RING_DEPTH;
    return int'(ring_cap);
  endfunction

  task automatic ring_clear();
    ring_head = 0;
    ring_tail = 0;
    ring_held = 0;
  endtask

  task automatic predict_item(input logic op, input logic [MSG_W-1:0] data);
    int            cap;
    logic          was_full;
    queue_result_t r;
    cap = effective_capacity();
    if (op == OP_PUSH) begin
      // push on a full ring throws everything away, then stores
      was_full = (ring_held >= cap);
      if (was_full) ring_clear();
      if (ring_tail >= cap) ring_tail = 0;
      ring_words[ring_tail] = data;
      ring_tail++;
      if (ring_tail >= cap) ring_tail = 0;
      ring_held++;
      r.kind     = KIND_ACK;
      r.msg      = '0;
      r.last     = 1'b1;
      r.flushed  = was_full;
      r.doorbell = (ring_held == 1);
      r.fill     = CAP_W'(ring_held);
      expected_results.push_back(r);
    end else begin
      // drain: one message per held entry, oldest first; none when empty
      while (ring_held > 0) begin
        if (ring_head >= cap) ring_head = 0;
        r.msg = ring_words[ring_head];
        ring_head++;
        if (ring_head >= cap) ring_head = 0;
        ring_held--;
        r.kind     = KIND_MSG;
        r.last     = (ring_held == 0);
        r.flushed  = 1'b0;
        r.doorbell = 1'b0;
        r.fill     = CAP_W'(ring_held);
        expected_results.push_back(r);
      end
    end
  endtask

  // ---------------------------------------------------------------------
  // Driver: start/operation/msg_data hold until the item is taken.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    queue_item_t nxt;
    if (rst) begin
      start <= 1'b0;
      ring_clear();
      ring_cap = CAP_RESET;
    end else begin
      if (start && !busy) predict_item(operation, msg_data);
      if (!start || !busy) begin
        if (pending_items.size() > 0 &&
            (steady_feed || $urandom_range(99) >= GAP_PERCENT)) begin
          nxt = pending_items.pop_front();
          start     <= 1'b1;
          operation <= nxt.op;
          msg_data  <= nxt.data;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: every strobed result is checked against the oldest expectation.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    queue_result_t got;
    queue_result_t want;
    if (!rst && result_valid) begin
      got = '{result_kind, msg_out, last, flushed, doorbell, fill_count};
      if (expected_results.size() == 0) begin
        if (mismatches < MAX_REPORTS)
          $display("unexpected result: kind=%0d msg=%h last=%0d flushed=%0d bell=%0d fill=%0d",
                   got.kind, got.msg, got.last, got.flushed, got.doorbell, got.fill);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          if (mismatches < MAX_REPORTS) begin
            $display("mismatch exp: kind=%0d msg=%h last=%0d flushed=%0d bell=%0d fill=%0d",
                     want.kind, want.msg, want.last, want.flushed, want.doorbell,
                     want.fill);
            $display("         got: kind=%0d msg=%h last=%0d flushed=%0d bell=%0d fill=%0d",
                     got.kind, got.msg, got.last, got.flushed, got.doorbell, got.fill);
          end
          mismatches++;
        end
      end
    end
  end

  // Watchdog: a stuck handshake or a missing result ends the run.
  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("flushing_ring_message_queue_tb: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------
  task automatic add_item(input logic op, input logic [MSG_W-1:0] data);
    queue_item_t it;
    it.op   = op;
    it.data = data;
    pending_items.push_back(it);
  endtask

  function automatic logic [MSG_W-1:0] pick_word();
    int sel;
    sel = $urandom_range(9);
    if (sel == 0) return '0;
    if (sel == 1) return '1;
    return $urandom;
  endfunction

  // Wait until every item is in and every result is out, then let any
  // drain of an empty ring finish before touching the register.
  task automatic settle();
    while (pending_items.size() > 0 || start || expected_results.size() > 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB write: setup cycle, then access cycle until pready.
  task automatic set_capacity(input logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CAPACITY_ADDR;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    // register taken at this edge; the ring restarts empty
    ring_cap = value[CAP_W-1:0];
    ring_clear();
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    pwdata  <= '0;
  endtask

  // Mostly push runs closed by a drain; the rest are lone random items.
  task automatic random_phase(input int budget);
    int cap;
    int n;
    int k;
    cap = effective_capacity();
    n = 0;
    while (n < budget) begin
      if ($urandom_range(99) < 80) begin
        if (cap <= 8)
          k = $urandom_range(cap + 1);
        else if ($urandom_range(9) == 0)
          k = $urandom_range(cap + 1, cap - 1);   // near full or one past
        else
          k = $urandom_range(8);
        repeat (k) add_item(OP_PUSH, pick_word());
        add_item(OP_DRAIN, pick_word());
        n += k + 1;
      end else begin
        add_item($urandom_range(1) ? OP_DRAIN : OP_PUSH, pick_word());
        n++;
      end
    end
  endtask

  function automatic logic [31:0] noisy_cap(input logic [CAP_W-1:0] cap);
    logic [31:0] v;
    v = $urandom;
    v[CAP_W-1:0] = cap;   // upper bits are not part of the register
    return v;
  endfunction

  // ---------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------
  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // reset capacity: drain of empty, extreme words, drain of three, drain of empty
    add_item(OP_DRAIN, '1);
    add_item(OP_PUSH, '0);
    add_item(OP_PUSH, '1);
    add_item(OP_PUSH, 32'hA5A5_5A5A);
    add_item(OP_DRAIN, '0);
    add_item(OP_DRAIN, 32'h1234_5678);
    settle();

    // single entry: every push after the first flushes
    set_capacity(32'd1);
    add_item(OP_PUSH, 32'h0000_0001);
    add_item(OP_PUSH, 32'h8000_0000);
    add_item(OP_PUSH, 32'h5555_AAAA);
    add_item(OP_DRAIN, '0);
    settle();

    // zero behaves as one
    set_capacity(32'd0);
    add_item(OP_PUSH, 32'hDEAD_BEEF);
    add_item(OP_PUSH, 32'hCAFE_F00D);
    add_item(OP_DRAIN, '0);
    settle();

    // three entries: fourth push flushes, second drain finds nothing
    set_capacity(32'd3);
    add_item(OP_PUSH, 32'h0000_0011);
    add_item(OP_PUSH, 32'h0000_0022);
    add_item(OP_PUSH, 32'h0000_0033);
    add_item(OP_PUSH, 32'h0000_0044);
    add_item(OP_DRAIN, '0);
    add_item(OP_DRAIN, '0);
    settle();

    // two entries: pointers wrap around the ring end
    set_capacity(32'd2);
    add_item(OP_PUSH, 32'h0000_00A1);
    add_item(OP_DRAIN, '0);
    add_item(OP_PUSH, 32'h0000_00B2);
    add_item(OP_PUSH, 32'h0000_00C3);
    add_item(OP_DRAIN, '0);
    settle();

    // above the built depth: full ring of 64, then a flushing push
    set_capacity(noisy_cap(7'd127));
    repeat (RING_DEPTH) add_item(OP_PUSH, pick_word());
    add_item(OP_PUSH, pick_word());
    add_item(OP_DRAIN, '0);
    random_phase(20);
    settle();

    set_capacity(noisy_cap(7'd5));
    random_phase(45);
    settle();

    // long stretch with back-to-back items
    steady_feed = 1'b1;
    set_capacity(noisy_cap(7'd64));
    random_phase(45);
    settle();
    steady_feed = 1'b0;

    set_capacity(noisy_cap(7'd1));
    random_phase(30);
    settle();

    set_capacity(noisy_cap(7'd2));
    random_phase(35);
    settle();

    set_capacity(noisy_cap(CAP_W'($urandom_range(63, 9))));
    random_phase(40);
    settle();

    set_capacity(noisy_cap(7'd0));
    random_phase(20);
    settle();

    set_capacity(noisy_cap(7'd65));
    random_phase(35);
    settle();

    set_capacity(noisy_cap(7'd7));
    random_phase(40);
    settle();

    set_capacity(noisy_cap(CAP_W'($urandom_range(8, 3))));
    random_phase(40);
    settle();

    if (mismatches == 0) begin
      $display("flushing_ring_message_queue_tb: clean");
    end else begin
      $display("flushing_ring_message_queue_tb: errors");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/frmq_pkg.sv
hdl/frmq_ram.sv
hdl/flushing_ring_message_queue.sv
hdl/frmq_chk.sv
tb/sv/flushing_ring_message_queue_tb.sv
